/* src/mfde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_pkg - shared definitions for the monochrome framebuffer draw engine
// Panel geometry, derived widths, command kinds, rotation codes and the
// payload structs of the command and response channels.
// ----------------------------------------------------------------------------
package mfde_pkg;

   localparam int PANEL_WIDTH  = 256;
   localparam int PANEL_HEIGHT = 256;
   localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
   localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;

   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int XW     = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
   localparam int YW     = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
   localparam int LW     = (XW > YW) ? XW : YW;
   localparam int COLW   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

   localparam int KIND_W      = 3;
   localparam int COORD_W     = 16;
   localparam int SUM_W       = COORD_W + 2;
   localparam int BYTE_ADDR_W = 13;
   localparam int TOTAL_W     = 17;

   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(ROW_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_BYTES - 1);

   localparam logic [KIND_W-1:0] KIND_PIXEL = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_HLINE = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_VLINE = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_FILL  = KIND_W'(3);
   localparam logic [KIND_W-1:0] KIND_COUNT = KIND_W'(4);
   localparam logic [KIND_W-1:0] KIND_PEEK  = KIND_W'(5);

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] span_length;
      logic                      ink;
      logic [BYTE_ADDR_W-1:0]    byte_address;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic [TOTAL_W-1:0] set_pixel_total;
   } rsp_payload_type;

endpackage

/* src/mfde_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfde_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mono_framebuffer_draw_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine - one-bit framebuffer drawing engine
// Pixel, line, fill, count and byte read commands on a packed, LSB-first,
// row-major framebuffer held in one RAM, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  Commands arrive on the req_ channel (valid/ready) and each gives exactly
//  one item on the rsp_ channel. read_data and set_pixel_total are zero
//  except for the read-byte and count kinds. csr_write_enable writes the
//  rotation register; write it only while the engine is idle.
//  One command is worked on at a time; req_ready is high only when idle.
//  Pixel and line commands pass each byte they touch through the single RAM
//  port pair as a read-modify-write (a read state, then a write state); a
//  panel-vertical run touches one byte per row, and an empty or clipped-away
//  line touches none. Fill writes and count reads the whole store, one byte
//  per cycle; read byte reads one byte, and an unused kind goes straight to
//  the response state. After reset a clearing pass writes white over the
//  whole store, one byte a cycle (STORE_BYTES = 8192 bytes), during which no
//  command is accepted.
//  The response register holds its item while rsp_ready is low; a new command
//  is accepted meanwhile and its own result waits until the register is free.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine
   import mfde_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [1:0]      csr_write_data
);

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_CLIP      = 14'b00000000000010,
      S_CLAMP     = 14'b00000000000100,
      S_MAP       = 14'b00000000001000,
      S_ORDER     = 14'b00000000010000,
      S_BASE      = 14'b00000000100000,
      S_RD        = 14'b00000001000000,
      S_WR        = 14'b00000010000000,
      S_FILL      = 14'b00000100000000,
      S_COUNT     = 14'b00001000000000,
      S_CNT_TAIL  = 14'b00010000000000,
      S_PEEK      = 14'b00100000000000,
      S_PEEK_DATA = 14'b01000000000000,
      S_RESP      = 14'b10000000000000
   } state_type;

   function automatic logic [XW-1:0] panel_x(logic [1:0] rot, logic [LW-1:0] lx,
                                             logic [LW-1:0] ly);
      logic [XW-1:0] result;
      unique case (rot)
         ROT_0:   result = XW'(lx);
         ROT_90:  result = XW'(PANEL_WIDTH - 1) - XW'(ly);
         ROT_180: result = XW'(PANEL_WIDTH - 1) - XW'(lx);
         ROT_270: result = XW'(ly);
      endcase
      return result;
   endfunction

   function automatic logic [YW-1:0] panel_y(logic [1:0] rot, logic [LW-1:0] lx,
                                             logic [LW-1:0] ly);
      logic [YW-1:0] result;
      unique case (rot)
         ROT_0:   result = YW'(ly);
         ROT_90:  result = YW'(lx);
         ROT_180: result = YW'(PANEL_HEIGHT - 1) - YW'(ly);
         ROT_270: result = YW'(PANEL_HEIGHT - 1) - YW'(lx);
      endcase
      return result;
   endfunction

   function automatic logic [3:0] ones_in_byte(logic [7:0] value);
      logic [3:0] total;
      total = '0;
      for (int i = 0; i < 8; i++) begin
         total = total + 4'(value[i]);
      end
      return total;
   endfunction

   state_type state_ff, state_in;
   req_payload_type cmd_ff, cmd_in;
   logic [1:0] rotation_ff, rotation_in;

   logic signed [COORD_W-1:0] start_ff, start_in;
   logic signed [SUM_W-1:0]   end_raw_ff, end_raw_in;
   logic                      cross_ok_ff, cross_ok_in;
   logic [LW-1:0]             q_ff, q_in;
   logic [LW-1:0]             lo_ff, lo_in;
   logic [LW-1:0]             hi_ff, hi_in;
   logic [XW-1:0]             bx0_ff, bx0_in, bx1_ff, bx1_in;
   logic [YW-1:0]             by0_ff, by0_in, by1_ff, by1_in;
   logic [YW-1:0]             row_lo_ff, row_lo_in, row_hi_ff, row_hi_in;
   logic [COLW-1:0]           col_lo_ff, col_lo_in, col_hi_ff, col_hi_in;
   logic [7:0]                head_mask_ff, head_mask_in;
   logic [7:0]                tail_mask_ff, tail_mask_in;
   logic [7:0]                mid_mask_ff, mid_mask_in;
   logic [ADDR_W-1:0]         step_ff, step_in;
   logic [ADDR_W-1:0]         cur_ff, cur_in;
   logic [ADDR_W-1:0]         end_ff, end_in;
   logic                      first_ff, first_in;
   logic [7:0]                fill_byte_ff, fill_byte_in;
   logic                      respond_ff, respond_in;
   logic                      pend_ff, pend_in;
   logic [TOTAL_W-1:0]        acc_ff, acc_in;
   logic [7:0]                peek_ff, peek_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   // Clipping works along the line: x for pixels and horizontal lines,
   // y for vertical lines. A pixel is a horizontal line of length one.
   logic                      odd_rot;
   logic                      is_vert;
   logic signed [SUM_W-1:0]   lim_w, lim_h, along_lim, cross_lim;
   logic signed [COORD_W-1:0] along_pos, cross_pos, span_len;
   logic signed [SUM_W-1:0]   clamp_end;
   logic                      span_ok;
   logic [LW-1:0]             end_a_x, end_a_y, end_b_x, end_b_y;
   logic                      horiz;
   logic [XW-1:0]             bx_lo, bx_hi;
   logic [YW-1:0]             by_lo, by_hi;
   logic                      is_last;
   logic [7:0]                byte_mask, merged;
   logic [TOTAL_W:0]          acc_sum;
   logic                      peek_ok;

   assign odd_rot   = rotation_ff[0];
   assign is_vert   = cmd_ff.kind == KIND_VLINE;
   assign lim_w     = odd_rot ? SUM_W'(PANEL_HEIGHT) : SUM_W'(PANEL_WIDTH);
   assign lim_h     = odd_rot ? SUM_W'(PANEL_WIDTH) : SUM_W'(PANEL_HEIGHT);
   assign along_lim = is_vert ? lim_h : lim_w;
   assign cross_lim = is_vert ? lim_w : lim_h;
   assign along_pos = is_vert ? cmd_ff.pos_y : cmd_ff.pos_x;
   assign cross_pos = is_vert ? cmd_ff.pos_x : cmd_ff.pos_y;
   assign span_len  = (cmd_ff.kind == KIND_PIXEL) ? COORD_W'(1) : cmd_ff.span_length;

   assign clamp_end = (end_raw_ff > along_lim - SUM_W'(1)) ? along_lim - SUM_W'(1)
                                                            : end_raw_ff;
   assign span_ok   = cross_ok_ff && (SUM_W'(start_ff) <= clamp_end);

   assign end_a_x = is_vert ? q_ff : lo_ff;
   assign end_a_y = is_vert ? lo_ff : q_ff;
   assign end_b_x = is_vert ? q_ff : hi_ff;
   assign end_b_y = is_vert ? hi_ff : q_ff;

   assign horiz = by0_ff == by1_ff;
   assign bx_lo = (bx0_ff < bx1_ff) ? bx0_ff : bx1_ff;
   assign bx_hi = (bx0_ff < bx1_ff) ? bx1_ff : bx0_ff;
   assign by_lo = (by0_ff < by1_ff) ? by0_ff : by1_ff;
   assign by_hi = (by0_ff < by1_ff) ? by1_ff : by0_ff;

   assign is_last   = cur_ff == end_ff;
   assign byte_mask = mid_mask_ff & (first_ff ? head_mask_ff : 8'hFF)
                      & (is_last ? tail_mask_ff : 8'hFF);
   assign merged    = cmd_ff.ink ? (ram_rd_data | byte_mask) : (ram_rd_data & ~byte_mask);

   assign acc_sum = {1'b0, acc_ff} + {{(TOTAL_W - 3){1'b0}}, ones_in_byte(ram_rd_data)};
   assign peek_ok = int'(cmd_ff.byte_address) < STORE_BYTES;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rotation_in   = rotation_ff;
      start_in      = start_ff;
      end_raw_in    = end_raw_ff;
      cross_ok_in   = cross_ok_ff;
      q_in          = q_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      bx0_in        = bx0_ff;
      bx1_in        = bx1_ff;
      by0_in        = by0_ff;
      by1_in        = by1_ff;
      row_lo_in     = row_lo_ff;
      row_hi_in     = row_hi_ff;
      col_lo_in     = col_lo_ff;
      col_hi_in     = col_hi_ff;
      head_mask_in  = head_mask_ff;
      tail_mask_in  = tail_mask_ff;
      mid_mask_in   = mid_mask_ff;
      step_in       = step_ff;
      cur_in        = cur_ff;
      end_in        = end_ff;
      first_in      = first_ff;
      fill_byte_in  = fill_byte_ff;
      respond_in    = respond_ff;
      pend_in       = 1'b0;
      acc_in        = acc_ff;
      peek_in       = peek_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff;
      ram_wr_data   = merged;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cur_ff;

      if (csr_write_enable) begin
         rotation_in = csr_write_data;
      end

      // Count reads return in the cycle after they are issued.
      if (pend_ff) begin
         acc_in = acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_payload;
               acc_in  = '0;
               peek_in = '0;
               unique case (req_payload.kind)
                  KIND_PIXEL, KIND_HLINE, KIND_VLINE: begin
                     state_in = S_CLIP;
                  end
                  KIND_FILL: begin
                     cur_in       = '0;
                     fill_byte_in = req_payload.ink ? 8'hFF : 8'h00;
                     respond_in   = 1'b1;
                     state_in     = S_FILL;
                  end
                  KIND_COUNT: begin
                     cur_in   = '0;
                     state_in = S_COUNT;
                  end
                  KIND_PEEK: begin
                     state_in = S_PEEK;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_CLIP: begin
            start_in    = along_pos[COORD_W-1] ? '0 : along_pos;
            end_raw_in  = SUM_W'(along_pos) + SUM_W'(span_len) - SUM_W'(1);
            cross_ok_in = !cross_pos[COORD_W-1] && (SUM_W'(cross_pos) < cross_lim);
            q_in        = LW'(cross_pos);
            state_in    = S_CLAMP;
         end
         S_CLAMP: begin
            lo_in    = LW'(start_ff);
            hi_in    = LW'(clamp_end);
            state_in = span_ok ? S_MAP : S_RESP;
         end
         S_MAP: begin
            bx0_in   = panel_x(rotation_ff, end_a_x, end_a_y);
            by0_in   = panel_y(rotation_ff, end_a_x, end_a_y);
            bx1_in   = panel_x(rotation_ff, end_b_x, end_b_y);
            by1_in   = panel_y(rotation_ff, end_b_x, end_b_y);
            state_in = S_ORDER;
         end
         S_ORDER: begin
            if (horiz) begin
               row_lo_in     = by0_ff;
               row_hi_in     = by0_ff;
               col_lo_in     = COLW'(bx_lo >> 3);
               col_hi_in     = COLW'(bx_hi >> 3);
               head_mask_in  = 8'hFF << bx_lo[2:0];
               tail_mask_in  = 8'hFF >> (3'd7 - bx_hi[2:0]);
               mid_mask_in   = 8'hFF;
               step_in       = ADDR_W'(1);
            end else begin
               row_lo_in     = by_lo;
               row_hi_in     = by_hi;
               col_lo_in     = COLW'(bx0_ff >> 3);
               col_hi_in     = COLW'(bx0_ff >> 3);
               head_mask_in  = 8'hFF;
               tail_mask_in  = 8'hFF;
               mid_mask_in   = 8'd1 << bx0_ff[2:0];
               step_in       = ROW_STRIDE;
            end
            state_in = S_BASE;
         end
         S_BASE: begin
            cur_in   = ADDR_W'(row_lo_ff) * ROW_STRIDE + ADDR_W'(col_lo_ff);
            end_in   = ADDR_W'(row_hi_ff) * ROW_STRIDE + ADDR_W'(col_hi_ff);
            first_in = 1'b1;
            state_in = S_RD;
         end
         S_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_WR;
         end
         S_WR: begin
            ram_wr_en = 1'b1;
            if (is_last) begin
               state_in = S_RESP;
            end else begin
               cur_in   = cur_ff + step_ff;
               first_in = 1'b0;
               state_in = S_RD;
            end
         end
         S_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = fill_byte_ff;
            if (cur_ff == LAST_ADDR) begin
               state_in = respond_ff ? S_RESP : S_IDLE;
            end else begin
               cur_in = cur_ff + ADDR_W'(1);
            end
         end
         S_COUNT: begin
            ram_rd_en = 1'b1;
            pend_in   = 1'b1;
            if (cur_ff == LAST_ADDR) begin
               state_in = S_CNT_TAIL;
            end else begin
               cur_in = cur_ff + ADDR_W'(1);
            end
         end
         S_CNT_TAIL: begin
            state_in = S_RESP;
         end
         S_PEEK: begin
            ram_rd_en   = peek_ok;
            ram_rd_addr = ADDR_W'(cmd_ff.byte_address);
            state_in    = S_PEEK_DATA;
         end
         S_PEEK_DATA: begin
            if (peek_ok) begin
               peek_in = ram_rd_data;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.read_data       = peek_ff;
               rsp_data_in.set_pixel_total = acc_ff;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         rotation_ff  <= ROT_0;
         cur_ff       <= '0;
         fill_byte_ff <= 8'hFF;
         respond_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rotation_ff  <= rotation_in;
         cur_ff       <= cur_in;
         fill_byte_ff <= fill_byte_in;
         respond_ff   <= respond_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      start_ff      <= start_in;
      end_raw_ff    <= end_raw_in;
      cross_ok_ff   <= cross_ok_in;
      q_ff          <= q_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      bx0_ff        <= bx0_in;
      bx1_ff        <= bx1_in;
      by0_ff        <= by0_in;
      by1_ff        <= by1_in;
      row_lo_ff     <= row_lo_in;
      row_hi_ff     <= row_hi_in;
      col_lo_ff     <= col_lo_in;
      col_hi_ff     <= col_hi_in;
      head_mask_ff  <= head_mask_in;
      tail_mask_ff  <= tail_mask_in;
      mid_mask_ff   <= mid_mask_in;
      step_ff       <= step_in;
      end_ff        <= end_in;
      first_ff      <= first_in;
      acc_ff        <= acc_in;
      peek_ff       <= peek_in;
      rsp_data_ff   <= rsp_data_in;
   end

   mfde_ram #(
      .WIDTH(8),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready   = state_ff == S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
